// ===== hw/rtl/fsp_pkg.sv =====
package fsp_pkg;

    localparam int INDEX_BITS    = 16;
    localparam int CORDIC_STAGES = 18;
    localparam int QUOT_BITS     = 31;
    localparam int VEC_BITS      = 34;

    localparam logic [31:0] GOLDEN_TURNS = 32'h61C88647;
    localparam logic signed [VEC_BITS-1:0] CORDIC_K = 34'sd652032874;

    // configuration register indexes
    localparam logic REG_POINT_COUNT   = 1'b0;
    localparam logic REG_SPHERE_RADIUS = 1'b1;

    // item moving through the divider cells
    typedef struct packed {
        logic                  valid;
        logic                  err;
        logic                  neg;
        logic                  flip;
        logic [31:0]           phase;
        logic [INDEX_BITS:0]   rem;
        logic [QUOT_BITS-1:0]  quot;
    } div_item_t;

    // item moving through the rotation cells: polar and azimuth vectors
    typedef struct packed {
        logic                        valid;
        logic                        err;
        logic                        flip;
        logic signed [VEC_BITS-1:0]  px;
        logic signed [VEC_BITS-1:0]  py;
        logic signed [VEC_BITS-1:0]  pz;
        logic signed [VEC_BITS-1:0]  ax;
        logic signed [VEC_BITS-1:0]  ay;
        logic signed [VEC_BITS-1:0]  az;
    } cordic_item_t;

    // arctangent of 2^-i in turns, Q0.32
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/fsp_div_cell.sv =====
module fsp_div_cell
    import fsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [INDEX_BITS-1:0] count,
    input  div_item_t             din,
    output div_item_t             dout
);

    div_item_t             item_reg;
    div_item_t             item_next;
    logic [INDEX_BITS+1:0] rem2;
    logic [INDEX_BITS+1:0] diff;
    logic                  ge;

    // one restoring step: one quotient bit
    always_comb
    begin
        rem2      = {din.rem, 1'b0};
        diff      = rem2 - {2'b00, count};
        ge        = (rem2 >= {2'b00, count});
        item_next = din;
        item_next.rem  = ge ? diff[INDEX_BITS:0] : rem2[INDEX_BITS:0];
        item_next.quot = {din.quot[QUOT_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign dout = item_reg;

endmodule

// ===== hw/rtl/fsp_cordic_cell.sv =====
module fsp_cordic_cell
    import fsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [4:0]   shift,
    input  logic [31:0]  atan,
    input  cordic_item_t din,
    output cordic_item_t dout
);

    cordic_item_t               item_reg;
    cordic_item_t               item_next;
    logic signed [VEC_BITS-1:0] step;

    // one micro-rotation of both vectors
    always_comb
    begin
        step      = $signed({2'b00, atan});
        item_next = din;
        if (!din.pz[VEC_BITS-1])
        begin
            item_next.px = din.px - (din.py >>> shift);
            item_next.py = din.py + (din.px >>> shift);
            item_next.pz = din.pz - step;
        end
        else
        begin
            item_next.px = din.px + (din.py >>> shift);
            item_next.py = din.py - (din.px >>> shift);
            item_next.pz = din.pz + step;
        end
        if (!din.az[VEC_BITS-1])
        begin
            item_next.ax = din.ax - (din.ay >>> shift);
            item_next.ay = din.ay + (din.ax >>> shift);
            item_next.az = din.az - step;
        end
        else
        begin
            item_next.ax = din.ax + (din.ay >>> shift);
            item_next.ay = din.ay - (din.ax >>> shift);
            item_next.az = din.az + step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign dout = item_reg;

endmodule

// ===== hw/rtl/fibonacci_sphere_point_top.sv =====
// channel   direction  contents
// s_*       in         tdata: point_index
// m_*       out        tdata: coord_x, coord_y, coord_z; tuser: index_error
// cfg_*     in         write: 0 point_count, 1 sphere_radius
//
// one item per cycle while the output is not stalled; 31 divider cells
// (one quotient bit each), 18 rotation cells, two multiply stages.
// all stages advance together; a stall holds the whole row in place.
// reset sets point_count to 255 and sphere_radius to 256 and empties the row.
module fibonacci_sphere_point_top
    import fsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // point_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // coord_x, coord_y, coord_z, zero fill
    output logic        m_tuser,   // index_error
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_data
);

    logic [15:0] point_count_reg;
    logic [15:0] sphere_radius_reg;
    logic        en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg   <= 16'd255;
            sphere_radius_reg <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_POINT_COUNT:   point_count_reg   <= cfg_data;
                REG_SPHERE_RADIUS: sphere_radius_reg <= cfg_data;
                default:           point_count_reg   <= point_count_reg;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // front: count, range check, polar numerator, azimuth phase
    logic [INDEX_BITS-1:0]   n_eff;
    logic [INDEX_BITS-1:0]   idx;
    logic [INDEX_BITS+1:0]   num;
    logic [INDEX_BITS+1:0]   mag;
    logic [INDEX_BITS-1:0]   kmul;
    logic [INDEX_BITS+31:0]  prod_k;
    logic [31:0]             phase;
    div_item_t               front;

    assign n_eff = {point_count_reg[INDEX_BITS-1:1], 1'b1};
    assign idx   = s_tdata[INDEX_BITS-1:0];

    always_comb
    begin
        num    = {1'b0, idx, 1'b1} - {2'b00, n_eff};
        mag    = num[INDEX_BITS+1] ? (~num + 1'b1) : num;
        kmul   = ((idx + 1'b1) == n_eff) ? '0 : idx + 1'b1;
        prod_k = kmul * GOLDEN_TURNS;
        phase  = prod_k[31:0];
        front.valid = s_tvalid;
        front.err   = (idx >= n_eff);
        front.neg   = num[INDEX_BITS+1];
        front.flip  = phase[31] ^ phase[30];
        front.phase = front.flip ? (phase + 32'h80000000) : phase;
        front.rem   = mag[INDEX_BITS:0];
        front.quot  = '0;
    end

    // divider cells
    div_item_t div_chain [QUOT_BITS+1];
    assign div_chain[0] = front;

    genvar g;
    generate
        for (g = 0; g < QUOT_BITS; g++)
        begin : g_div
            fsp_div_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en),
                .count (n_eff),
                .din   (div_chain[g]),
                .dout  (div_chain[g+1])
            );
        end
    endgenerate

    // polar angle from rounded quotient, start vectors
    div_item_t                  dq;
    logic [QUOT_BITS:0]         qsum;
    logic signed [VEC_BITS-1:0] theta_mag;
    cordic_item_t               cstart;

    assign dq = div_chain[QUOT_BITS];

    always_comb
    begin
        qsum      = {1'b0, dq.quot} + 1'b1;
        theta_mag = $signed({3'b000, qsum[QUOT_BITS:1]});
        cstart.valid = dq.valid;
        cstart.err   = dq.err;
        cstart.flip  = dq.flip;
        cstart.px    = CORDIC_K;
        cstart.py    = '0;
        cstart.pz    = dq.neg ? -theta_mag : theta_mag;
        cstart.ax    = CORDIC_K;
        cstart.ay    = '0;
        cstart.az    = $signed({{(VEC_BITS-32){dq.phase[31]}}, dq.phase});
    end

    // rotation cells
    cordic_item_t cor_chain [CORDIC_STAGES+1];
    assign cor_chain[0] = cstart;

    generate
        for (g = 0; g < CORDIC_STAGES; g++)
        begin : g_cor
            fsp_cordic_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en),
                .shift (5'(g)),
                .atan  (atan_turns(5'(g))),
                .din   (cor_chain[g]),
                .dout  (cor_chain[g+1])
            );
        end
    endgenerate

    // ring radius times azimuth cosine and sine
    cordic_item_t                 ce;
    logic signed [VEC_BITS-1:0]   ring;
    logic signed [VEC_BITS-1:0]   ac;
    logic signed [VEC_BITS-1:0]   as_v;
    logic signed [2*VEC_BITS-1:0] mx;
    logic signed [2*VEC_BITS-1:0] my;
    logic                         a_valid_reg;
    logic                         a_err_reg;
    logic signed [VEC_BITS-1:0]   rx_reg;
    logic signed [VEC_BITS-1:0]   ry_reg;
    logic signed [VEC_BITS-1:0]   rz_reg;

    assign ce = cor_chain[CORDIC_STAGES];

    always_comb
    begin
        ring = ce.px[VEC_BITS-1] ? '0 : ce.px;
        ac   = ce.flip ? -ce.ax : ce.ax;
        as_v = ce.flip ? -ce.ay : ce.ay;
        mx   = ac * ring + (68'sd1 <<< 29);
        my   = as_v * ring + (68'sd1 <<< 29);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= ce.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_err_reg <= ce.err;
            rx_reg    <= mx[VEC_BITS+29:30];
            ry_reg    <= my[VEC_BITS+29:30];
            rz_reg    <= ce.py;
        end
    end

    // radius scaling, rounding and saturation into the output register
    function automatic logic [24:0] scale_out(input logic signed [VEC_BITS-1:0] v,
                                              input logic [15:0] radius);
        logic signed [VEC_BITS+16:0] p;
        logic signed [VEC_BITS-6:0]  s;
        logic [24:0]                 r;
        p = v * $signed({1'b0, radius}) + (51'sd1 <<< 21);
        s = p[VEC_BITS+16:22];
        if (s > 29'sd16777215)
            r = 25'h0FFFFFF;
        else if (s < -29'sd16777216)
            r = 25'h1000000;
        else
            r = s[24:0];
        return r;
    endfunction

    logic        out_valid_reg;
    logic        out_err_reg;
    logic [24:0] out_x_reg;
    logic [24:0] out_y_reg;
    logic [24:0] out_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_err_reg <= a_err_reg;
            out_x_reg   <= a_err_reg ? '0 : scale_out(rx_reg, sphere_radius_reg);
            out_y_reg   <= a_err_reg ? '0 : scale_out(ry_reg, sphere_radius_reg);
            out_z_reg   <= a_err_reg ? '0 : scale_out(rz_reg, sphere_radius_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_err_reg;
    assign m_tdata  = {5'b00000, out_z_reg, out_y_reg, out_x_reg};

    // an out-of-range item carries zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[74:0] == '0))
        else $error("error item with nonzero coordinates");

    // input side may stall only while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with output free");

    // a result that waits is still there next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("waiting result changed");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import fsp_pkg::*;

    localparam int LATENCY = 51;

    // result fields of one item
    typedef struct {
        logic signed [24:0] cx;
        logic signed [24:0] cy;
        logic signed [24:0] cz;
        logic               err;
    } point_t;

    // one row of the directed table; has_exp marks a typed-in result
    typedef struct {
        logic        is_cfg;
        logic        addr;
        logic [15:0] val;
        logic        has_exp;
        point_t      exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // point_index
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // coord_x, coord_y, coord_z, zero fill
    logic        m_tuser;   // index_error
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_data;

    logic [15:0] cur_count;
    logic [15:0] cur_radius;
    point_t      point_q[$];
    int          fail_cnt;

    fibonacci_sphere_point_top u_dut (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // arithmetic shift right
    function automatic longint sra(input longint v, input int s);
        return v >>> s;
    endfunction

    // own copy of the arctangent table
    function automatic logic [31:0] atan_val(input int i);
        logic [31:0] tbl[31];
        tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
                32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
                32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
                32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
                32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
                32'h00000001};
        return tbl[i];
    endfunction

    // rotation-mode vector rotation, angle in turns
    function automatic void rotate(input longint ang, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = 652032874;
        y = 0;
        z = ang;
        for (int i = 0; i < CORDIC_STAGES && i < 31; i++)
        begin
            dx = sra(y, i);
            dy = sra(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(atan_val(i));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(atan_val(i));
            end
        end
        c = x;
        s = y;
    endfunction

    // scale by radius and round to signed Q16.8 with saturation
    function automatic logic signed [24:0] scale_q16(input longint v, input longint rad);
        longint p;
        p = sra(v * rad + (longint'(1) << 21), 22);
        if (p > 16777215)
            p = 16777215;
        if (p < -16777216)
            p = -16777216;
        return p[24:0];
    endfunction

    // lattice point for one index
    function automatic point_t lattice_point(input logic [15:0] idx);
        point_t  res;
        longint  n;
        longint  num;
        longint  mag;
        longint  q;
        longint  theta;
        longint  pc;
        longint  ps;
        longint  ac;
        longint  as_v;
        longint  r;
        longint  k;
        longint  a;
        logic [31:0] phase;
        logic    flip;
        n = longint'(cur_count | 16'd1);
        if (longint'(idx) >= n)
        begin
            res.cx = '0;
            res.cy = '0;
            res.cz = '0;
            res.err = 1'b1;
            return res;
        end
        num = 2 * longint'(idx) + 1 - n;
        mag = num < 0 ? -num : num;
        q = ((mag << 31) / n + 1) >> 1;
        theta = num < 0 ? -q : q;
        rotate(theta, pc, ps);
        r = pc < 0 ? 0 : pc;
        k = (longint'(idx) + 1 == n) ? 0 : longint'(idx) + 1;
        phase = 32'(k * longint'(GOLDEN_TURNS));
        flip = phase[31] != phase[30];
        if (flip)
            phase += 32'h80000000;
        a = longint'(signed'(phase));
        rotate(a, ac, as_v);
        if (flip)
        begin
            ac = -ac;
            as_v = -as_v;
        end
        res.cx = scale_q16(sra(ac * r + (longint'(1) << 29), 30), longint'(cur_radius));
        res.cy = scale_q16(sra(as_v * r + (longint'(1) << 29), 30), longint'(cur_radius));
        res.cz = scale_q16(ps, longint'(cur_radius));
        res.err = 1'b0;
        return res;
    endfunction

    // register write, block idle
    task automatic write_reg(input logic addr, input logic [15:0] val);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_addr = addr;
        cfg_data = val;
        @(negedge clk);
        cfg_we   = 1'b0;
        if (addr == REG_POINT_COUNT)
            cur_count = val;
        else
            cur_radius = val;
    endtask

    // wait until all results are back, then idle while the pipeline runs empty
    task automatic drain();
        while (point_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // send one index, bursty sender
    task automatic send_index(input logic [15:0] idx, input logic has_exp, input point_t e);
        point_t p;
        p = lattice_point(idx);
        if (has_exp)
            p = e;
        s_tvalid <= 1'b1;
        s_tdata  <= idx;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        point_q.insert(point_q.size(), p);
        @(negedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    // pick a random index, mostly in range
    function automatic logic [15:0] rand_index();
        logic [15:0] n;
        n = cur_count | 16'd1;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return n - 16'd1;
            2: return n;
            default: return 16'($urandom_range(0, int'(n) - 1));
        endcase
    endfunction

    // receiver stall pattern
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            case ($urandom_range(0, 7))
                0, 1: m_tready = 1'b0;
                default: m_tready = 1'b1;
            endcase
        end
    end

    // result checking
    always @(posedge clk)
    begin
        point_t e;
        logic signed [24:0] ax;
        logic signed [24:0] ay;
        logic signed [24:0] az;
        if (rst_n && m_tvalid && m_tready)
        begin
            ax = m_tdata[24:0];
            ay = m_tdata[49:25];
            az = m_tdata[74:50];
            if (point_q.size() == 0)
            begin
                $error("result with no expectation waiting");
                fail_cnt++;
            end
            else
            begin
                e = point_q.pop_front();
                if (ax !== e.cx)
                begin
                    $error("coord_x expected %0d actual %0d", e.cx, ax);
                    fail_cnt++;
                end
                if (ay !== e.cy)
                begin
                    $error("coord_y expected %0d actual %0d", e.cy, ay);
                    fail_cnt++;
                end
                if (az !== e.cz)
                begin
                    $error("coord_z expected %0d actual %0d", e.cz, az);
                    fail_cnt++;
                end
                if (m_tuser !== e.err)
                begin
                    $error("index_error expected %0d actual %0d", e.err, m_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #(12 * 400000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // stimulus
    initial
    begin
        row_t   rows[21];
        row_t   rw;
        point_t zero_err;
        point_t none;
        logic [15:0] cnts[6];
        logic [15:0] rads[5];
        zero_err = '{cx: '0, cy: '0, cz: '0, err: 1'b1};
        none = '{cx: '0, cy: '0, cz: '0, err: 1'b0};
        fail_cnt = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        cfg_we   = 1'b0;
        cfg_addr = REG_POINT_COUNT;
        cfg_data = '0;
        cur_count  = 16'd255;
        cur_radius = 16'd256;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table: index rows after reset, then config extremes
        rows = '{
            '{1'b0, 1'b0, 16'd0, 1'b0, none},
            '{1'b0, 1'b0, 16'd127, 1'b0, none},
            '{1'b0, 1'b0, 16'd254, 1'b0, none},
            '{1'b0, 1'b0, 16'd255, 1'b1, zero_err},
            '{1'b0, 1'b0, 16'hFFFF, 1'b1, zero_err},
            '{1'b1, REG_POINT_COUNT, 16'd0, 1'b0, none},
            '{1'b0, 1'b0, 16'd0, 1'b0, none},
            '{1'b0, 1'b0, 16'd1, 1'b1, zero_err},
            '{1'b1, REG_POINT_COUNT, 16'd8, 1'b0, none},
            '{1'b0, 1'b0, 16'd8, 1'b0, none},
            '{1'b0, 1'b0, 16'd9, 1'b1, zero_err},
            '{1'b1, REG_POINT_COUNT, 16'hFFFF, 1'b0, none},
            '{1'b1, REG_SPHERE_RADIUS, 16'hFFFF, 1'b0, none},
            '{1'b0, 1'b0, 16'd0, 1'b0, none},
            '{1'b0, 1'b0, 16'd32767, 1'b0, none},
            '{1'b0, 1'b0, 16'hFFFE, 1'b0, none},
            '{1'b0, 1'b0, 16'hFFFF, 1'b1, zero_err},
            '{1'b1, REG_SPHERE_RADIUS, 16'd0, 1'b0, none},
            '{1'b0, 1'b0, 16'd100, 1'b0, none},
            '{1'b0, 1'b0, 16'h5555, 1'b0, none},
            '{1'b0, 1'b0, 16'hAAAA, 1'b0, none}
        };
        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.is_cfg)
            begin
                s_tvalid <= 1'b0;
                drain();
                write_reg(rw.addr, rw.val);
            end
            else
                send_index(rw.val, rw.has_exp, rw.exp);
        end
        s_tvalid <= 1'b0;
        drain();

        // random phases over several settings
        cnts = '{16'd1, 16'd2, 16'd255, 16'd1000, 16'hFFFF, 16'd0};
        rads = '{16'd256, 16'hFFFF, 16'd1, 16'd0, 16'd700};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_POINT_COUNT, ph == 5 ? 16'($urandom) : cnts[ph]);
            write_reg(REG_SPHERE_RADIUS, ph == 5 ? 16'($urandom) : rads[ph % 5]);
            for (int j = 0; j < 100; j++)
            begin
                if (j == 50)
                begin
                    // hold off until every result is back
                    s_tvalid <= 1'b0;
                    while (point_q.size() != 0)
                        @(negedge clk);
                end
                send_index(rand_index(), 1'b0, none);
            end
            s_tvalid <= 1'b0;
            drain();
        end

        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
